/* src/fvdf_pkg.sv */
// ----------------------------------------------------------------------------
// fvdf_pkg
// Shared types and constants for the four-view disparity fusion core.
// ----------------------------------------------------------------------------
package fvdf_pkg;

  localparam int DISP_W = 8;
  localparam int THR_W  = 9;
  localparam int SUM_W  = 10;
  localparam int CNT_W  = 3;
  localparam int CFG_ADDR_W = 1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PAIR_THR   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIPLE_THR = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 9'd3;

  // floor(x/3) = (x * 683) >> 11 for x < 1024
  localparam int RECIP3_W     = 10;
  localparam int RECIP3_SHIFT = 11;
  localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;

  typedef logic [DISP_W-1:0] disp_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // final scaling of the selected numerator
  typedef logic [1:0] op_t;
  localparam op_t OP_ZERO  = 2'd0;
  localparam op_t OP_PASS  = 2'd1;
  localparam op_t OP_HALF  = 2'd2;
  localparam op_t OP_THIRD = 2'd3;

endpackage

/* src/fvdf_div.sv */
// ----------------------------------------------------------------------------
// fvdf_div
// Scales the selected numerator: zero, pass, halve or divide by three.
// ----------------------------------------------------------------------------
module fvdf_div (
  input  fvdf_pkg::sum_t  num,
  input  fvdf_pkg::op_t   op,
  output fvdf_pkg::disp_t res
);
  import fvdf_pkg::*;

  logic [SUM_W+RECIP3_W-1:0] prod;

  assign prod = (SUM_W+RECIP3_W)'(num) * (SUM_W+RECIP3_W)'(RECIP3);

  always_comb begin
    case (op)
      OP_ZERO:  res = '0;
      OP_PASS:  res = num[DISP_W-1:0];
      OP_HALF:  res = num[DISP_W:1];
      OP_THIRD: res = prod[RECIP3_SHIFT +: DISP_W];
      default:  res = '0;
    endcase
  end

endmodule

/* src/four_view_disparity_fusion_core.sv */
// ----------------------------------------------------------------------------
// four_view_disparity_fusion_core
// Fuses four per-pixel disparities (east, north, west, south) into one.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless m_tready stalls; each input beat
//   reaches m_tvalid through four register stages, each stage holds
//   under backpressure and frees as soon as the next one moves.
// Reset (rst, synchronous): clears all stage valid bits and sets both
//   thresholds to 3.
// ----------------------------------------------------------------------------
module four_view_disparity_fusion_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fvdf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fvdf_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // disp_east[7:0], disp_north[15:8], disp_west[23:16], disp_south[31:24]
  input  logic [4*fvdf_pkg::DISP_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fused_disp[7:0]
  output logic [fvdf_pkg::DISP_W-1:0]       m_tdata
);
  import fvdf_pkg::*;

  logic [THR_W-1:0] pair_thr;
  logic [THR_W-1:0] triple_thr;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // stage 1: compacted views
  logic [CNT_W-1:0] s1_n;
  disp_t            s1_v [4];
  logic [CNT_W-1:0] s1_n_next;
  disp_t            s1_v_next [4];

  // stage 2: closeness, sum, extremes
  logic [CNT_W-1:0] s2_n;
  disp_t            s2_v [3];
  logic             s2_c01, s2_c02, s2_c12;
  sum_t             s2_sum;
  disp_t            s2_lo, s2_hi;

  // stage 3: numerator and scaling
  sum_t s3_num;
  op_t  s3_op;

  // comb
  logic [THR_W-1:0] thr;
  disp_t            d01, d02, d12;
  disp_t            lo_a, lo_b, hi_a, hi_b;
  sum_t             s3_num_next;
  op_t              s3_op_next;
  logic [1:0]       nclose;
  disp_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_thr   <= THR_RESET;
      triple_thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_PAIR_THR:   pair_thr   <= cfg_wdata;
        CFG_TRIPLE_THR: triple_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake chain
  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: pack nonzero views to the front, keep order
  always_comb begin
    disp_t d;
    s1_n_next = '0;
    for (int i = 0; i < 4; i++) s1_v_next[i] = '0;
    for (int i = 0; i < 4; i++) begin
      d = s_tdata[i*DISP_W +: DISP_W];
      if (d != '0) begin
        s1_v_next[s1_n_next[1:0]] = d;
        s1_n_next = s1_n_next + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_n <= s1_n_next;
      for (int i = 0; i < 4; i++) s1_v[i] <= s1_v_next[i];
    end
  end

  // stage 2
  assign thr = (s1_n == CNT_W'(2)) ? pair_thr : triple_thr;
  assign d01 = (s1_v[0] > s1_v[1]) ? s1_v[0] - s1_v[1] : s1_v[1] - s1_v[0];
  assign d02 = (s1_v[0] > s1_v[2]) ? s1_v[0] - s1_v[2] : s1_v[2] - s1_v[0];
  assign d12 = (s1_v[1] > s1_v[2]) ? s1_v[1] - s1_v[2] : s1_v[2] - s1_v[1];
  assign lo_a = (s1_v[0] < s1_v[1]) ? s1_v[0] : s1_v[1];
  assign lo_b = (s1_v[2] < s1_v[3]) ? s1_v[2] : s1_v[3];
  assign hi_a = (s1_v[0] > s1_v[1]) ? s1_v[0] : s1_v[1];
  assign hi_b = (s1_v[2] > s1_v[3]) ? s1_v[2] : s1_v[3];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_n   <= s1_n;
      for (int i = 0; i < 3; i++) s2_v[i] <= s1_v[i];
      s2_c01 <= {1'b0, d01} < thr;
      s2_c02 <= {1'b0, d02} < thr;
      s2_c12 <= {1'b0, d12} < thr;
      s2_sum <= (SUM_W'(s1_v[0]) + SUM_W'(s1_v[1])) + (SUM_W'(s1_v[2]) + SUM_W'(s1_v[3]));
      s2_lo  <= (lo_a < lo_b) ? lo_a : lo_b;
      s2_hi  <= (hi_a > hi_b) ? hi_a : hi_b;
    end
  end

  // stage 3: choose numerator and scaling by view count
  assign nclose = 2'(s2_c01) + 2'(s2_c02) + 2'(s2_c12);

  always_comb begin
    s3_num_next = s2_sum;
    s3_op_next  = OP_ZERO;
    case (s2_n)
      CNT_W'(1): s3_op_next = OP_PASS;
      CNT_W'(2): s3_op_next = s2_c01 ? OP_HALF : OP_ZERO;
      CNT_W'(3): begin
        case (nclose)
          2'd3: s3_op_next = OP_THIRD;
          2'd2: begin
            s3_op_next = OP_PASS;
            if (!s2_c01)      s3_num_next = SUM_W'(s2_v[2]);
            else if (!s2_c02) s3_num_next = SUM_W'(s2_v[1]);
            else              s3_num_next = SUM_W'(s2_v[0]);
          end
          2'd1: begin
            s3_op_next = OP_HALF;
            if (s2_c01)      s3_num_next = SUM_W'(s2_v[0]) + SUM_W'(s2_v[1]);
            else if (s2_c02) s3_num_next = SUM_W'(s2_v[0]) + SUM_W'(s2_v[2]);
            else             s3_num_next = SUM_W'(s2_v[1]) + SUM_W'(s2_v[2]);
          end
          default: s3_op_next = OP_ZERO;
        endcase
      end
      CNT_W'(4): begin
        s3_op_next  = OP_HALF;
        s3_num_next = s2_sum - SUM_W'(s2_lo) - SUM_W'(s2_hi);
      end
      default: s3_op_next = OP_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_num <= s3_num_next;
      s3_op  <= s3_op_next;
    end
  end

  // stage 4: scale and register the result
  fvdf_div u_div (
    .num (s3_num),
    .op  (s3_op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (en4) m_tdata <= res;
  end

`ifndef NO_ASSERTIONS
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && s3_op == OP_ZERO) |=> (m_tdata == '0))
    else $error("rejected pixel gave nonzero result");

  a_pass_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && s3_op == OP_PASS) |=> (m_tdata == $past(s3_num[DISP_W-1:0])))
    else $error("pass-through result mismatch");

  a_half_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && s3_op == OP_HALF) |=> (m_tdata == $past(s3_num[DISP_W:1])))
    else $error("mean of pair mismatch");
`endif

endmodule

/* dv/fvdf_checker.sv */
// ----------------------------------------------------------------------------
// fvdf_checker
// Watches the config port and both stream channels of the fusion core,
// predicts the fused disparity of every accepted input beat and compares each
// output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module fvdf_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fvdf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fvdf_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [4*fvdf_pkg::DISP_W-1:0]     s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [fvdf_pkg::DISP_W-1:0]       m_tdata,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fvdf_pkg::*;

  logic [THR_W-1:0] pair_thr;
  logic [THR_W-1:0] triple_thr;
  disp_t            expected_fused[$];
  int               mismatch_count;

  initial begin
    fail_count     = 0;
    pending        = 0;
    mismatch_count = 0;
    pair_thr       = THR_RESET;
    triple_thr     = THR_RESET;
  end

  function automatic bit is_near(int unsigned a, int unsigned b, logic [THR_W-1:0] thr);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d < thr;
  endfunction

  function automatic disp_t fuse_views(logic [4*DISP_W-1:0] beat);
    int unsigned v[4];
    int unsigned lo, hi, sum, r;
    int n;
    bit c01, c02, c12;
    n = 0;
    r = 0;
    for (int i = 0; i < 4; i++) begin
      if (beat[DISP_W*i +: DISP_W] != '0) begin
        v[n] = beat[DISP_W*i +: DISP_W];
        n++;
      end
    end
    case (n)
      1: r = v[0];
      2: begin
        if (is_near(v[0], v[1], pair_thr)) r = (v[0] + v[1]) / 2;
      end
      3: begin
        c01 = is_near(v[0], v[1], triple_thr);
        c02 = is_near(v[0], v[2], triple_thr);
        c12 = is_near(v[1], v[2], triple_thr);
        case (int'(c01) + int'(c02) + int'(c12))
          3: r = (v[0] + v[1] + v[2]) / 3;
          2: r = !c01 ? v[2] : (!c02 ? v[1] : v[0]);
          1: r = c01 ? (v[0] + v[1]) / 2 : (c02 ? (v[0] + v[2]) / 2 : (v[1] + v[2]) / 2);
          default: r = 0;
        endcase
      end
      4: begin
        lo  = v[0];
        hi  = v[0];
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          if (v[i] < lo) lo = v[i];
          if (v[i] > hi) hi = v[i];
          sum += v[i];
        end
        r = (sum - lo - hi) / 2;
      end
      default: r = 0;
    endcase
    return disp_t'(r);
  endfunction

  always @(posedge clk) begin
    disp_t want;
    if (rst) begin
      pair_thr   = THR_RESET;
      triple_thr = THR_RESET;
      expected_fused.delete();
    end else begin
      if (s_tvalid && s_tready) expected_fused.push_back(fuse_views(s_tdata));
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_PAIR_THR:   pair_thr   = cfg_wdata;
          CFG_TRIPLE_THR: triple_thr = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_fused.size() == 0) begin
          $error("fused_disp: expected none, actual %0d", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_fused.pop_front();
          if (m_tdata !== want) begin
            $error("fused_disp: expected %0d, actual %0d", want, m_tdata);
            mismatch_count++;
          end
        end
      end
    end
    fail_count <= mismatch_count;
    pending    <= expected_fused.size();
  end

endmodule

/* dv/tb_four_view_disparity_fusion_core.sv */
// ----------------------------------------------------------------------------
// tb_four_view_disparity_fusion_core
// Drives directed corner pixels and clustered random pixels through the
// fusion core under several threshold settings, with random gaps on the input
// and random backpressure on the output; the checker scores every beat.
// ----------------------------------------------------------------------------
module tb_four_view_disparity_fusion_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fvdf_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_PAIR_THR;
  logic [THR_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [4*DISP_W-1:0]   s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [DISP_W-1:0]     m_tdata;
  int                    fail_count;
  int                    pending;

  logic [4*DISP_W-1:0]   pixel_q[$];
  int                    idle_pct    = 0;
  int                    send_gap    = 0;
  int                    recv_gap    = 0;
  int                    quiet_cycles = 0;

  four_view_disparity_fusion_core uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fvdf_checker chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // input side: one beat at a time from pixel_q, random gap bursts
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (pixel_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        s_tvalid <= 1'b0;
        send_gap = $urandom_range(0, 3);
      end else begin
        s_tdata  <= pixel_q.pop_front();
        s_tvalid <= 1'b1;
      end
    end
  end

  // output side backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      m_tready <= 1'b0;
      recv_gap = $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_pixel(int east, int north, int west, int south);
    pixel_q.push_back({disp_t'(south), disp_t'(west), disp_t'(north), disp_t'(east)});
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [THR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_thresholds(int pair_val, int triple_val);
    write_reg(CFG_PAIR_THR, THR_W'(pair_val));
    write_reg(CFG_TRIPLE_THR, THR_W'(triple_val));
    @(negedge clk);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // views cluster around a base value so the closeness cases are hit often
  task automatic add_random(int count);
    int base, spread, val;
    logic [3:0] mask;
    int views[4];
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        pixel_q.push_back($urandom);
      end else begin
        mask   = 4'($urandom_range(0, 15));
        base   = $urandom_range(1, 255);
        spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 6);
        for (int i = 0; i < 4; i++) begin
          val = base + $urandom_range(0, 2 * spread) - spread;
          if (val < 1) val = 1;
          if (val > 255) val = 255;
          views[i] = mask[i] ? val : 0;
        end
        add_pixel(views[0], views[1], views[2], views[3]);
      end
    end
  endtask

  initial begin
    int pair_val, triple_val;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    @(negedge clk);
    // reset thresholds (3, 3)
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 0, 0, 0);
    add_pixel(0, 1, 0, 0);
    add_pixel(0, 0, 128, 0);
    add_pixel(0, 0, 0, 255);
    add_pixel(10, 12, 0, 0);
    add_pixel(0, 10, 0, 13);
    add_pixel(255, 0, 254, 0);
    add_pixel(1, 0, 0, 2);
    add_pixel(10, 11, 12, 0);
    add_pixel(10, 0, 12, 14);
    add_pixel(0, 10, 11, 50);
    add_pixel(10, 50, 0, 100);
    add_pixel(255, 255, 254, 0);
    add_pixel(1, 255, 128, 2);
    add_pixel(255, 255, 255, 255);
    add_pixel(1, 1, 1, 1);
    add_pixel(170, 85, 85, 170);
    drain();
    // zero thresholds: nothing is ever close
    set_thresholds(0, 0);
    add_pixel(5, 5, 0, 0);
    add_pixel(7, 7, 7, 0);
    add_pixel(0, 7, 9, 7);
    drain();
    // thresholds above 255: everything is close
    set_thresholds(511, 256);
    add_pixel(1, 255, 0, 0);
    add_pixel(1, 128, 255, 0);
    add_pixel(0, 255, 255, 254);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin pair_val = 3;   triple_val = 3;   end
        1: begin pair_val = 0;   triple_val = 1;   end
        2: begin pair_val = 1;   triple_val = 0;   end
        3: begin pair_val = 255; triple_val = 256; end
        4: begin pair_val = 511; triple_val = 511; end
        5: begin pair_val = 2;   triple_val = 5;   end
        6: begin pair_val = $urandom_range(0, 511); triple_val = $urandom_range(0, 511); end
        default: begin
          pair_val   = $urandom_range(0, 16);
          triple_val = $urandom_range(0, 16);
        end
      endcase
      set_thresholds(pair_val, triple_val);
      idle_pct = (ph == 8 || ph % 3 == 1) ? 0 : 25;
      add_random(150);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
